@@ hdl/assert_macros.svh @@
// Assertion helpers for the RTL; only the heap sequencer includes them.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion, disabled while reset is asserted.
`define HPQ_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Clocked assertion that is also checked during reset.
`define HPQ_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) (prop)) else $error(msg);

`endif

@@ hdl/hpq_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Indexed heap package
// Widths, codes, payload types and saturating arithmetic for the heap.
// ----------------------------------------------------------------------------
package hpq_pkg;

  localparam int CAPACITY = 256;
  localparam int HANDLES  = 256;
  localparam int HANDLE_W = 8;
  localparam int PRIO_W   = 32;
  localparam int SLOT_W   = $clog2(CAPACITY);
  localparam int CNT_W    = $clog2(CAPACITY + 1);
  localparam int OP_W     = 3;
  localparam int STAT_W   = 3;

  typedef logic [SLOT_W-1:0]   slot_t;
  typedef logic [CNT_W-1:0]    cnt_t;
  typedef logic [HANDLE_W-1:0] handle_t;
  typedef logic signed [PRIO_W-1:0] prio_t;

  typedef enum logic [OP_W-1:0] {
    OP_INSERT = 3'd0,
    OP_POP    = 3'd1,
    OP_CHANGE = 3'd2,
    OP_ERASE  = 3'd3,
    OP_DELTA  = 3'd4
  } op_e;

  typedef enum logic [STAT_W-1:0] {
    ST_OK      = 3'd0,
    ST_FULL    = 3'd1,
    ST_EMPTY   = 3'd2,
    ST_ABSENT  = 3'd3,
    ST_PRESENT = 3'd4
  } status_e;

  typedef struct packed {
    handle_t handle;
    prio_t   prio;
  } entry_t;

  typedef struct packed {
    handle_t             front_handle;
    prio_t               front_priority;
    cnt_t                entry_count;
    logic                is_empty;
    logic [STAT_W-1:0]   status;
  } result_t;

  // Saturating add of two signed priorities.
  function automatic prio_t sat_add(prio_t a, prio_t b);
    logic signed [PRIO_W:0] sum;
    sum = {a[PRIO_W-1], a} + {b[PRIO_W-1], b};
    if (sum[PRIO_W] != sum[PRIO_W-1]) begin
      return sum[PRIO_W] ? {1'b1, {(PRIO_W-1){1'b0}}} : {1'b0, {(PRIO_W-1){1'b1}}};
    end
    return sum[PRIO_W-1:0];
  endfunction

endpackage

@@ hdl/hpq_if.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Heap channel interfaces
// Request and response channels with valid/ready handshake.
// ----------------------------------------------------------------------------
interface hpq_req_if;
  import hpq_pkg::*;
  logic        valid;
  logic        ready;
  logic [2:0]  op;
  logic [7:0]  handle;
  logic signed [31:0] priority_req;
  logic signed [31:0] delta;

  modport source (output valid, op, handle, priority_req, delta, input ready);
  modport sink   (input valid, op, handle, priority_req, delta, output ready);
endinterface

interface hpq_rsp_if;
  logic        valid;
  logic        ready;
  logic [7:0]  front_handle;
  logic signed [31:0] front_priority;
  logic [8:0]  entry_count;
  logic        is_empty;
  logic [2:0]  status;

  modport source (output valid, front_handle, front_priority, entry_count, is_empty,
                  status, input ready);
  modport sink   (input valid, front_handle, front_priority, entry_count, is_empty,
                  status, output ready);
endinterface

@@ hdl/indexed_max_priority_heap.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Indexed max-priority heap
// Handle-tagged priority queue kept as a binary heap in synchronous RAM.
// ----------------------------------------------------------------------------
// Usage: requests arrive on req_i (op, handle, priority_req, delta) and one
// result per request leaves on rsp_o (front handle and priority, count,
// empty flag, status). A transfer happens when valid and ready are both high.
// One request is worked on at a time; req_i.ready is high only when idle.
// Steps per request: an error or unknown op only reads the front; insert
// compares one parent per level on its way up; a sift down reads the children
// per level; change, pop and erase read their slot, and pop and erase the last
// entry, before the sift; add-delta rewrites each held entry in turn.
// The walk is set by the single read port of the slot RAM, whose read data
// is registered. The worst sift is 8 levels.
// The result sits in an output register, so a new request is taken while an
// earlier result still waits; a stalled receiver holds the block only when the
// next result is ready and the register is still full.
// Reset clears the count and the presence bits; the RAMs are not cleared and
// need no clearing pass, as no slot's data is used before it is written.
// ----------------------------------------------------------------------------
module indexed_max_priority_heap
  import hpq_pkg::*;
(
  input  logic    clk_i,
  input  logic    rst_ni,
  hpq_req_if.sink   req_i,
  hpq_rsp_if.source rsp_o
);

  result_t res;
  logic    res_valid;

  // The sequencer owns both memories and the output register; its result is
  // driven onto the response channel here.
  hpq_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_i       (req_i),
    .res_o       (res),
    .res_valid_o (res_valid),
    .res_ready_i (rsp_o.ready)
  );

  assign rsp_o.valid          = res_valid;
  assign rsp_o.front_handle   = res.front_handle;
  assign rsp_o.front_priority = res.front_priority;
  assign rsp_o.entry_count    = res.entry_count;
  assign rsp_o.is_empty       = res.is_empty;
  assign rsp_o.status         = res.status;

endmodule

@@ hdl/hpq_ram.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Heap RAM
// Simple dual-port synchronous RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
module hpq_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    rdata_o <= mem[raddr_i];
  end

endmodule

@@ hdl/hpq_ctrl.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Heap sequencer
// Runs each request over the slot and map RAMs, one heap level at a time.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module hpq_ctrl
  import hpq_pkg::*;
(
  input  logic          clk_i,
  input  logic          rst_ni,
  hpq_req_if.sink       req_i,
  output result_t       res_o,
  output logic          res_valid_o,
  input  logic          res_ready_i
);

  typedef enum logic [3:0] {
    S_IDLE, S_MAP_RD, S_MAP_GET, S_CHG_GET, S_POP_GET, S_REM, S_LAST_GET,
    S_UP_RD, S_UP_GET, S_DN_L, S_DN_LGET, S_DN_RGET, S_DN_CMP, S_PLACE,
    S_DLT_RD, S_DLT_GET
  } state_e;

  // The front is read in the F_RD and F_GET steps of front_e, outside state_e.
  typedef enum logic [1:0] {F_NONE, F_RD, F_GET} front_e;

  state_e  state_q, state_d;
  front_e  front_q, front_d;
  slot_t   s_q, s_d, cslot_q, cslot_d, i_q, i_d;
  handle_t h_q, h_d;
  prio_t   p_q, p_d, d_q, d_d;
  op_e     op_q, op_d;
  logic [STAT_W-1:0] status_q, status_d;
  entry_t  c_q, c_d;
  logic    up_try_q, up_try_d;
  cnt_t    count_q, count_d;
  logic [HANDLES-1:0] present_q, present_d;
  result_t res_q, res_d;
  logic    res_valid_q, res_valid_d;

  logic    heap_we, map_we;
  slot_t   heap_waddr, heap_raddr, map_wdata, map_rdata;
  handle_t map_waddr, map_raddr;
  entry_t  heap_wdata, heap_rdata;

  hpq_ram #(.WIDTH(HANDLE_W + PRIO_W), .DEPTH(CAPACITY)) u_heap_ram (
    .clk_i   (clk_i),
    .we_i    (heap_we),
    .waddr_i (heap_waddr),
    .wdata_i (heap_wdata),
    .raddr_i (heap_raddr),
    .rdata_o (heap_rdata)
  );

  hpq_ram #(.WIDTH(SLOT_W), .DEPTH(HANDLES)) u_map_ram (
    .clk_i   (clk_i),
    .we_i    (map_we),
    .waddr_i (map_waddr),
    .wdata_i (map_wdata),
    .raddr_i (map_raddr),
    .rdata_o (map_rdata)
  );

  slot_t                parent;
  logic [SLOT_W:0]      lchild;
  logic [SLOT_W+1:0]    rchild;
  slot_t                last;
  logic                 fire;

  assign parent = (s_q - slot_t'(1)) >> 1;
  assign lchild = {s_q, 1'b1};
  assign rchild = {1'b0, lchild} + (SLOT_W+2)'(1);
  assign last   = slot_t'(count_q - cnt_t'(1));
  assign fire   = req_i.valid && req_i.ready;

  assign req_i.ready = (state_q == S_IDLE) && (front_q == F_NONE);
  assign res_o       = res_q;
  assign res_valid_o = res_valid_q;

  always_comb begin
    state_d     = state_q;
    front_d     = front_q;
    s_d         = s_q;
    cslot_d     = cslot_q;
    i_d         = i_q;
    h_d         = h_q;
    p_d         = p_q;
    d_d         = d_q;
    op_d        = op_q;
    status_d    = status_q;
    c_d         = c_q;
    up_try_d    = up_try_q;
    count_d     = count_q;
    present_d   = present_q;
    res_d       = res_q;
    res_valid_d = res_valid_q && !res_ready_i;
    heap_we     = 1'b0;
    heap_waddr  = s_q;
    heap_wdata  = c_q;
    heap_raddr  = '0;
    map_we      = 1'b0;
    map_waddr   = c_q.handle;
    map_wdata   = s_q;
    map_raddr   = h_q;

    unique case (state_q)
      S_IDLE: begin
        if (fire) begin
          op_d     = op_e'(req_i.op);
          h_d      = req_i.handle;
          p_d      = req_i.priority_req;
          d_d      = req_i.delta;
          status_d = ST_OK;
          up_try_d = 1'b0;
          front_d  = F_RD;
          case (req_i.op)
            OP_INSERT: begin
              if (present_q[req_i.handle]) begin
                status_d = ST_PRESENT;
              end else if (count_q == cnt_t'(CAPACITY)) begin
                status_d = ST_FULL;
              end else begin
                present_d[req_i.handle] = 1'b1;
                s_d     = slot_t'(count_q);
                count_d = count_q + cnt_t'(1);
                state_d = S_UP_RD;
                front_d = F_NONE;
              end
            end
            OP_POP: begin
              if (count_q == '0) begin
                status_d = ST_EMPTY;
              end else begin
                state_d = S_POP_GET;
                front_d = F_NONE;
              end
            end
            OP_CHANGE, OP_ERASE: begin
              if (!present_q[req_i.handle]) begin
                status_d = ST_ABSENT;
              end else begin
                state_d = S_MAP_RD;
                front_d = F_NONE;
              end
            end
            OP_DELTA: begin
              if (count_q != '0) begin
                i_d     = '0;
                state_d = S_DLT_RD;
                front_d = F_NONE;
              end
            end
            default: ;
          endcase
        end else if (front_q == F_RD) begin
          front_d = F_GET;
        end else if (front_q == F_GET && !res_valid_d) begin
          res_d.entry_count    = count_q;
          res_d.is_empty       = (count_q == '0);
          res_d.status         = status_q;
          res_d.front_handle   = (count_q == '0) ? '0 : heap_rdata.handle;
          res_d.front_priority = (count_q == '0) ? '0 : heap_rdata.prio;
          res_valid_d          = 1'b1;
          front_d              = F_NONE;
        end
      end
      S_MAP_RD: begin
        state_d = S_MAP_GET;
      end
      S_MAP_GET: begin
        s_d        = map_rdata;
        heap_raddr = map_rdata;
        state_d    = (op_q == OP_CHANGE) ? S_CHG_GET : S_REM;
      end
      S_CHG_GET: begin
        if (p_q > heap_rdata.prio) begin
          state_d = S_UP_RD;
        end else if (p_q < heap_rdata.prio) begin
          state_d = S_DN_L;
        end else begin
          state_d = S_PLACE;
        end
      end
      S_POP_GET: begin
        h_d     = heap_rdata.handle;
        s_d     = '0;
        state_d = S_REM;
      end
      S_REM: begin
        present_d[h_q] = 1'b0;
        count_d        = count_q - cnt_t'(1);
        heap_raddr     = last;
        if (s_q == last) begin
          state_d = S_IDLE;
          front_d = F_RD;
        end else begin
          state_d = S_LAST_GET;
        end
      end
      S_LAST_GET: begin
        h_d      = heap_rdata.handle;
        p_d      = heap_rdata.prio;
        up_try_d = 1'b1;
        state_d  = S_UP_RD;
      end
      S_UP_RD: begin
        heap_raddr = parent;
        if (s_q == '0) begin
          state_d = up_try_q ? S_DN_L : S_PLACE;
        end else begin
          state_d = S_UP_GET;
        end
      end
      S_UP_GET: begin
        if (heap_rdata.prio < p_q) begin
          heap_we    = 1'b1;
          heap_wdata = heap_rdata;
          map_we     = 1'b1;
          map_waddr  = heap_rdata.handle;
          s_d        = parent;
          up_try_d   = 1'b0;
          state_d    = S_UP_RD;
        end else begin
          state_d = up_try_q ? S_DN_L : S_PLACE;
        end
      end
      S_DN_L: begin
        heap_raddr = lchild[SLOT_W-1:0];
        state_d    = (lchild >= count_q) ? S_PLACE : S_DN_LGET;
      end
      S_DN_LGET: begin
        c_d        = heap_rdata;
        cslot_d    = lchild[SLOT_W-1:0];
        heap_raddr = rchild[SLOT_W-1:0];
        state_d    = (rchild < {1'b0, count_q}) ? S_DN_RGET : S_DN_CMP;
      end
      S_DN_RGET: begin
        if (heap_rdata.prio > c_q.prio) begin
          c_d     = heap_rdata;
          cslot_d = rchild[SLOT_W-1:0];
        end
        state_d = S_DN_CMP;
      end
      S_DN_CMP: begin
        if (c_q.prio > p_q) begin
          heap_we = 1'b1;
          map_we  = 1'b1;
          s_d     = cslot_q;
          state_d = S_DN_L;
        end else begin
          state_d = S_PLACE;
        end
      end
      S_PLACE: begin
        heap_we    = 1'b1;
        heap_wdata = '{handle: h_q, prio: p_q};
        map_we     = 1'b1;
        map_waddr  = h_q;
        state_d    = S_IDLE;
        front_d    = F_RD;
      end
      S_DLT_RD: begin
        heap_raddr = i_q;
        state_d    = S_DLT_GET;
      end
      S_DLT_GET: begin
        heap_we    = 1'b1;
        heap_waddr = i_q;
        heap_wdata = '{handle: heap_rdata.handle, prio: sat_add(heap_rdata.prio, d_q)};
        i_d        = i_q + slot_t'(1);
        if (cnt_t'(i_q) + cnt_t'(1) == count_q) begin
          state_d = S_IDLE;
          front_d = F_RD;
        end else begin
          state_d = S_DLT_RD;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      front_q     <= F_NONE;
      count_q     <= '0;
      present_q   <= '0;
      res_valid_q <= 1'b0;
      up_try_q    <= 1'b0;
    end else begin
      state_q     <= state_d;
      front_q     <= front_d;
      count_q     <= count_d;
      present_q   <= present_d;
      res_valid_q <= res_valid_d;
      up_try_q    <= up_try_d;
    end
  end

  always_ff @(posedge clk_i) begin
    s_q      <= s_d;
    cslot_q  <= cslot_d;
    i_q      <= i_d;
    h_q      <= h_d;
    p_q      <= p_d;
    d_q      <= d_d;
    op_q     <= op_d;
    status_q <= status_d;
    c_q      <= c_d;
    res_q    <= res_d;
  end

  `HPQ_ASSERT(a_count_bound, count_q <= cnt_t'(CAPACITY), "entry count above capacity")
  `HPQ_ASSERT(a_insert_grows,
    fire && req_i.op == OP_INSERT && !present_q[req_i.handle] && count_q != cnt_t'(CAPACITY)
    |=> count_q == $past(count_q) + cnt_t'(1), "accepted insert did not grow count")
  `HPQ_ASSERT(a_no_accept_busy, state_q != S_IDLE |-> !req_i.ready, "request taken while busy")
  `HPQ_ASSERT(a_move_pairs, heap_we && state_q != S_DLT_GET |-> map_we,
    "slot moved without map update")

endmodule

@@ verif/indexed_max_priority_heap_tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Indexed max-priority heap testbench
// Sends insert, pop, change, erase, add-delta and unused-op requests with random
// bursts and receiver stalls, and checks every response against a heap predictor.
// ----------------------------------------------------------------------------
module indexed_max_priority_heap_tb;
  import hpq_pkg::*;

  localparam longint PRIO_HI = 64'sd2147483647;
  localparam longint PRIO_LO = -64'sd2147483648;
  localparam int IDLE_LIMIT = 6000;
  localparam int RANDOM_ITEMS = 650;

  // The predictor keeps its own array heap and handle-to-slot map. A slot is
  // read only below the entry count, and a map entry only while its handle
  // is held.
  class heap_scoreboard;
    handle_t  slot_h[CAPACITY];
    longint   slot_p[CAPACITY];
    int       slot_of[HANDLES];
    bit       held[HANDLES];
    int       cnt;
    result_t  expected_q[$];
    int       errors;
    int       checked;
    int       full_hits;
    int       sat_hits;

    function new();
      cnt = 0;
      errors = 0;
      checked = 0;
      full_hits = 0;
      sat_hits = 0;
      foreach (held[i]) held[i] = 1'b0;
    endfunction

    function void place(int s, handle_t h, longint p);
      slot_h[s] = h;
      slot_p[s] = p;
      slot_of[h] = s;
    endfunction

    // Walk toward the root; a parent of equal priority stops the walk.
    function void raise_entry(int s);
      handle_t h;
      longint p;
      int par;
      h = slot_h[s];
      p = slot_p[s];
      while (s > 0) begin
        par = (s - 1) / 2;
        if (!(slot_p[par] < p)) break;
        place(s, slot_h[par], slot_p[par]);
        s = par;
      end
      place(s, h, p);
    endfunction

    // Walk toward the leaves; the left child wins a tie between children.
    function void lower_entry(int s);
      handle_t h;
      longint p;
      int l;
      int c;
      h = slot_h[s];
      p = slot_p[s];
      forever begin
        l = 2 * s + 1;
        if (l >= cnt) break;
        c = l;
        if (l + 1 < cnt && slot_p[l + 1] > slot_p[l]) c = l + 1;
        if (!(slot_p[c] > p)) break;
        place(s, slot_h[c], slot_p[c]);
        s = c;
      end
      place(s, h, p);
    endfunction

    function void drop_slot(int s);
      int last;
      last = cnt - 1;
      held[slot_h[s]] = 1'b0;
      cnt = last;
      if (s != last) begin
        place(s, slot_h[last], slot_p[last]);
        if (s > 0 && slot_p[(s - 1) / 2] < slot_p[s]) raise_entry(s);
        else lower_entry(s);
      end
    endfunction

    function longint sat_sum(longint a, longint b);
      longint sum;
      sum = a + b;
      if (sum > PRIO_HI) begin
        sat_hits++;
        return PRIO_HI;
      end
      if (sum < PRIO_LO) begin
        sat_hits++;
        return PRIO_LO;
      end
      return sum;
    endfunction

    // Notes one accepted request and queues the response it must produce.
    function void note_request(logic [2:0] op, handle_t h, prio_t preq, prio_t d);
      result_t r;
      status_e st;
      longint old;
      int s;
      st = ST_OK;
      case (op)
        OP_INSERT: begin
          if (held[h]) st = ST_PRESENT;
          else if (cnt >= CAPACITY) begin
            st = ST_FULL;
            full_hits++;
          end else begin
            held[h] = 1'b1;
            place(cnt, h, longint'(preq));
            cnt++;
            raise_entry(cnt - 1);
          end
        end
        OP_POP: begin
          if (cnt == 0) st = ST_EMPTY;
          else drop_slot(0);
        end
        OP_CHANGE: begin
          if (!held[h]) st = ST_ABSENT;
          else begin
            s = slot_of[h];
            old = slot_p[s];
            slot_p[s] = longint'(preq);
            if (longint'(preq) > old) raise_entry(s);
            else if (longint'(preq) < old) lower_entry(s);
          end
        end
        OP_ERASE: begin
          if (!held[h]) st = ST_ABSENT;
          else drop_slot(slot_of[h]);
        end
        OP_DELTA: begin
          for (int i = 0; i < cnt; i++) slot_p[i] = sat_sum(slot_p[i], longint'(d));
        end
        default: ;
      endcase
      r.front_handle   = (cnt == 0) ? '0 : slot_h[0];
      r.front_priority = (cnt == 0) ? '0 : prio_t'(slot_p[0]);
      r.entry_count    = cnt_t'(cnt);
      r.is_empty       = (cnt == 0);
      r.status         = st;
      expected_q.push_back(r);
    endfunction

    task report(string msg);
      errors++;
      $display("[%0t] MISMATCH response %0d: %s", $realtime, checked, msg);
    endtask

    task check_response(result_t got);
      result_t exp;
      if (expected_q.size() == 0) begin
        report("response with no request outstanding");
        return;
      end
      exp = expected_q.pop_front();
      if (got.front_handle !== exp.front_handle)
        report($sformatf("front_handle %0d, want %0d", got.front_handle, exp.front_handle));
      if (got.front_priority !== exp.front_priority)
        report($sformatf("front_priority %h, want %h", got.front_priority,
                         exp.front_priority));
      if (got.entry_count !== exp.entry_count)
        report($sformatf("entry_count %0d, want %0d", got.entry_count, exp.entry_count));
      if (got.is_empty !== exp.is_empty)
        report($sformatf("is_empty %b, want %b", got.is_empty, exp.is_empty));
      if (got.status !== exp.status)
        report($sformatf("status %0d, want %0d", got.status, exp.status));
      checked++;
    endtask

    // Returns a held handle most of the time, so that change and erase
    // reach the sift logic instead of the absent-handle path.
    function handle_t pick_held();
      handle_t h;
      for (int t = 0; t < 12; t++) begin
        h = handle_t'($urandom_range(0, 255));
        if (held[h]) return h;
      end
      return h;
    endfunction

    // Returns a handle that is not held, scanning up from a random start.
    function handle_t pick_free();
      handle_t h;
      h = handle_t'($urandom_range(0, 255));
      for (int t = 0; t < HANDLES; t++) begin
        if (!held[h]) return h;
        h = h + handle_t'(1);
      end
      return h;
    endfunction
  endclass

  logic clk_i;
  logic rst_ni;

  hpq_req_if req_if ();
  hpq_rsp_if rsp_if ();

  indexed_max_priority_heap u_top (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (req_if.sink),
    .rsp_o  (rsp_if.source)
  );

  heap_scoreboard heap_sb;
  int burst_left;
  int requests_sent;
  int op_seen[8];

  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  // Sends one request. Within a burst valid stays high from one transfer to
  // the next; a burst ends with a random gap, or sometimes with none.
  task automatic send_request(logic [2:0] op, handle_t h, prio_t p, prio_t d);
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 7);
      if (gap > 0) begin
        req_if.valid <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
      burst_left = $urandom_range(1, 24);
    end
    req_if.valid        <= 1'b1;
    req_if.op           <= op;
    req_if.handle       <= h;
    req_if.priority_req <= p;
    req_if.delta        <= d;
    do @(posedge clk_i); while (!req_if.ready);
    heap_sb.note_request(op, h, p, d);
    burst_left--;
    requests_sent++;
    op_seen[op]++;
  endtask

  // Holds the sender until the block has answered every request so far.
  task automatic drain_responses();
    req_if.valid <= 1'b0;
    burst_left = 0;
    while (heap_sb.expected_q.size() != 0) @(posedge clk_i);
  endtask

  function automatic prio_t rand_prio();
    case ($urandom_range(0, 5))
      0:       return prio_t'($urandom());
      1:       return prio_t'($signed($urandom_range(0, 8)) - 4) <<< 16;
      2:       return $urandom_range(0, 1) ? prio_t'(PRIO_HI) : prio_t'(PRIO_LO);
      3:       return prio_t'($signed($urandom_range(0, 2)) - 1) + prio_t'(PRIO_HI) - 1;
      default: return prio_t'($signed($urandom_range(0, 131072)) - 65536);
    endcase
  endfunction

  function automatic prio_t rand_delta();
    case ($urandom_range(0, 4))
      0:       return prio_t'($urandom());
      1:       return $urandom_range(0, 1) ? prio_t'(PRIO_HI) : prio_t'(PRIO_LO);
      default: return prio_t'($signed($urandom_range(0, 131072)) - 65536);
    endcase
  endfunction

  // One random request, with the op mix tilted by how full the heap is.
  task automatic random_request(int insert_weight);
    int r;
    r = $urandom_range(0, 99);
    if (r < insert_weight)
      send_request(OP_INSERT, handle_t'($urandom_range(0, 255)), rand_prio(), rand_delta());
    else if (r < insert_weight + 15)
      send_request(OP_POP, handle_t'($urandom()), rand_prio(), rand_delta());
    else if (r < insert_weight + 33)
      send_request(OP_CHANGE, heap_sb.pick_held(), rand_prio(), rand_delta());
    else if (r < insert_weight + 47)
      send_request(OP_ERASE, heap_sb.pick_held(), rand_prio(), rand_delta());
    else if (r < 97)
      send_request(OP_DELTA, handle_t'($urandom()), rand_prio(), rand_delta());
    else
      send_request(3'($urandom_range(5, 7)), handle_t'($urandom()), rand_prio(),
                   rand_delta());
  endtask

  // Receiver: ready cycles through three patterns in turn (always ready, coin
  // flip, one cycle in four), and once, after 200 responses, it holds off
  // while the sender keeps offering requests.
  int  rx_cycle;
  int  hold_left;
  bit  hold_done;
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rsp_if.ready <= 1'b0;
      rx_cycle     <= 0;
      hold_left    <= 0;
      hold_done    <= 1'b0;
    end else begin
      if (rsp_if.valid && rsp_if.ready) begin
        heap_sb.check_response(result_t'{rsp_if.front_handle, rsp_if.front_priority,
                                         rsp_if.entry_count, rsp_if.is_empty,
                                         rsp_if.status});
      end
      rx_cycle <= rx_cycle + 1;
      if (!hold_done && heap_sb.checked >= 200) begin
        hold_done    <= 1'b1;
        hold_left    <= 300;
        rsp_if.ready <= 1'b0;
      end else if (hold_left > 0) begin
        hold_left    <= hold_left - 1;
        rsp_if.ready <= 1'b0;
      end else begin
        case ((rx_cycle / 64) % 3)
          0:       rsp_if.ready <= 1'b1;
          1:       rsp_if.ready <= $urandom_range(0, 1);
          default: rsp_if.ready <= (rx_cycle % 4 == 0);
        endcase
      end
    end
  end

  // Watchdog: a long run of cycles with no transfer on either side means the
  // block has hung.
  initial begin
    int idle;
    idle = 0;
    while (idle < IDLE_LIMIT) begin
      @(posedge clk_i);
      if ((req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready)) idle = 0;
      else if (rst_ni) idle++;
    end
    $display("watchdog: no transfer for %0d cycles", IDLE_LIMIT);
    $display("end of test: mismatches");
    $finish;
  end

  initial begin
    heap_sb = new();
    burst_left = 0;
    requests_sent = 0;
    foreach (op_seen[i]) op_seen[i] = 0;
    rst_ni = 1'b0;
    req_if.valid = 1'b0;
    req_if.op = OP_INSERT;
    req_if.handle = '0;
    req_if.priority_req = '0;
    req_if.delta = '0;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed part: error paths on an empty heap, the unused op codes,
    // priority extremes, ties, an equal-priority change and saturation of
    // add-delta in both directions.
    send_request(OP_POP,    8'd0,   '0, '0);
    send_request(OP_ERASE,  8'd5,   '0, '0);
    send_request(OP_CHANGE, 8'd5,   '0, '0);
    send_request(3'd5,      8'd1,   '0, '0);
    send_request(3'd6,      8'd2,   '0, '0);
    send_request(3'd7,      8'd3,   '0, '0);
    send_request(OP_INSERT, 8'd0,   prio_t'(PRIO_HI), '0);
    send_request(OP_INSERT, 8'd255, prio_t'(PRIO_LO), '0);
    send_request(OP_INSERT, 8'd0,   '0, '0);
    send_request(OP_INSERT, 8'd7,   '0, '0);
    send_request(OP_INSERT, 8'd8,   '0, '0);
    send_request(OP_CHANGE, 8'd7,   '0, '0);
    send_request(OP_CHANGE, 8'd255, prio_t'(PRIO_HI), '0);
    send_request(OP_DELTA,  8'd0,   '0, prio_t'(PRIO_HI));
    send_request(OP_DELTA,  8'd0,   '0, prio_t'(PRIO_LO));
    send_request(OP_DELTA,  8'd0,   '0, prio_t'(PRIO_LO));
    send_request(OP_CHANGE, 8'd8,   -prio_t'(32'sd65536), '0);
    send_request(OP_ERASE,  8'd0,   '0, '0);
    send_request(OP_ERASE,  8'd0,   '0, '0);
    send_request(OP_POP,    8'd0,   '0, '0);
    send_request(OP_POP,    8'd0,   '0, '0);
    send_request(OP_POP,    8'd0,   '0, '0);
    send_request(OP_POP,    8'd0,   '0, '0);

    // Random part. A third of the way in, the heap is filled to capacity,
    // pushed past it, shaken with deltas and changes, then drained again.
    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      if (n == RANDOM_ITEMS / 3) begin
        drain_responses();
        while (heap_sb.cnt < CAPACITY) begin
          send_request(OP_INSERT, heap_sb.pick_free(), rand_prio(), '0);
        end
        send_request(OP_INSERT, heap_sb.pick_held(), rand_prio(), '0);
        for (int k = 0; k < 3; k++) begin
          send_request(OP_CHANGE, heap_sb.pick_held(), rand_prio(), '0);
          send_request(OP_DELTA, '0, '0, rand_delta());
        end
        send_request(OP_DELTA, '0, '0, prio_t'(PRIO_HI));
        send_request(OP_DELTA, '0, '0, prio_t'(PRIO_LO));
        send_request(OP_ERASE, heap_sb.pick_held(), '0, '0);
        send_request(OP_INSERT, heap_sb.pick_held(), rand_prio(), '0);
        while (heap_sb.cnt > 0) begin
          if ($urandom_range(0, 3) == 0)
            send_request(OP_ERASE, heap_sb.pick_held(), '0, '0);
          else
            send_request(OP_POP, '0, '0, '0);
        end
      end
      if (n == 2 * RANDOM_ITEMS / 3) drain_responses();
      random_request(heap_sb.cnt < 16 ? 55 : (heap_sb.cnt > 200 ? 20 : 38));
    end

    drain_responses();
    repeat (600) @(posedge clk_i);

    $display("covered %0d requests: insert %0d, pop %0d, change %0d, erase %0d, delta %0d",
             requests_sent, op_seen[0], op_seen[1], op_seen[2], op_seen[3], op_seen[4]);
    $display("unused ops %0d, full rejects %0d, saturated sums %0d, responses checked %0d",
             op_seen[5] + op_seen[6] + op_seen[7], heap_sb.full_hits, heap_sb.sat_hits,
             heap_sb.checked);
    if (heap_sb.errors == 0 && heap_sb.expected_q.size() == 0) begin
      $display("end of test: clean");
    end else begin
      if (heap_sb.expected_q.size() != 0)
        $display("%0d responses never arrived", heap_sb.expected_q.size());
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule

@@ indexed_max_priority_heap.f @@
+incdir+hdl
hdl/hpq_pkg.sv
hdl/hpq_if.sv
hdl/hpq_ram.sv
hdl/hpq_ctrl.sv
hdl/indexed_max_priority_heap.sv
verif/indexed_max_priority_heap_tb.sv
